// File: hdl/kolm_pkg.sv
`timescale 1ns / 1ps
package kolm_pkg;

  localparam int CAP = 32;
  localparam int AW  = $clog2(CAP);
  localparam int PW  = AW + 1;
  localparam logic [PW-1:0] NIL = PW'(CAP);

  localparam logic [2:0] CMD_APPEND  = 3'd0;
  localparam logic [2:0] CMD_PREPEND = 3'd1;
  localparam logic [2:0] CMD_INSERT  = 3'd2;
  localparam logic [2:0] CMD_DELETE  = 3'd3;
  localparam logic [2:0] CMD_UPDATE  = 3'd4;
  localparam logic [2:0] CMD_LIST    = 3'd5;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EXISTS  = 3'd1;
  localparam logic [2:0] ST_ANCMISS = 3'd2;
  localparam logic [2:0] ST_KEYMISS = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] item_key;
    logic signed [31:0] item_value;
    logic signed [31:0] target_key;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] out_key;
    logic signed [31:0] out_value;
    logic               last;
  } out_item_t;

endpackage

// File: hdl/keyed_ordered_list_manager.sv
`timescale 1ns / 1ps
// Walk: a command visits the list one node at a time (S_RD issues the read,
// then S_EV evaluates the registered memory data).
// Throughput: one command at a time; the walk over the single node memory read
// port sets the rate. List emits one item per node; a stalled output holds S_EV.
// Reset: asynchronous, active low; clears node valid bits, head (null), count.
module keyed_ordered_list_manager
  import kolm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  // controller states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1; // issue node read or end walk
  localparam logic [2:0] S_EV    = 3'd2; // node data valid
  localparam logic [2:0] S_ALLOC = 3'd3; // take lowest free node
  localparam logic [2:0] S_LINK  = 3'd4; // hook new node behind anchor
  localparam logic [2:0] S_STAT  = 3'd5; // emit single status item

  // walk kinds
  localparam logic [1:0] PH_FIND = 2'd0;
  localparam logic [1:0] PH_TAIL = 2'd1;
  localparam logic [1:0] PH_DEL  = 2'd2;
  localparam logic [1:0] PH_LIST = 2'd3;

  // node pool: key/value memory and link memory, one read address shared
  logic [63:0]   data_mem [CAP];
  logic [PW-1:0] link_mem [CAP];

  logic [2:0]    state_q, state_d;
  logic [1:0]    phase_q, phase_d;
  logic [2:0]    cmd_q, cmd_d, status_q, status_d;
  logic [31:0]   ikey_q, ikey_d, ival_q, ival_d, tkey_q, tkey_d;
  logic [PW-1:0] ptr_q, ptr_d, prev_q, prev_d, steps_q, steps_d;
  logic          prevv_q, prevv_d, second_q, second_d;
  logic [PW-1:0] anc_q, anc_d, alink_q, alink_d, new_q, new_d;
  logic [PW-1:0] head_q, head_d, count_q, count_d;
  logic [CAP-1:0] used_q, used_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_q, out_d;

  logic [31:0]   rd_key_q, rd_val_q;
  logic [PW-1:0] rd_link_q;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          dw_en, lw_en;
  logic [AW-1:0] dw_addr, lw_addr;
  logic [63:0]   dw_data;
  logic [PW-1:0] lw_data;

  logic          out_space, match, full;
  logic [31:0]   skey;
  logic [AW-1:0] free_idx;
  logic          free_found;

  function automatic logic node_ok(input logic [PW-1:0] p, input logic [CAP-1:0] u);
    return (p < NIL) && u[p[AW-1:0]];
  endfunction

  // lowest free node
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = CAP - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_idx   = AW'(i);
        free_found = 1'b1;
      end
    end
  end

  assign out_space = !out_valid_q || out_ready_i;
  assign skey = (second_q || cmd_q == CMD_APPEND || cmd_q == CMD_PREPEND) ? ikey_q : tkey_q;
  assign match = (rd_key_q == skey);
  assign full = (count_q >= NIL) || !free_found;

  always_comb begin
    state_d = state_q;   phase_d = phase_q;   cmd_d = cmd_q;   status_d = status_q;
    ikey_d = ikey_q;     ival_d = ival_q;     tkey_d = tkey_q;
    ptr_d = ptr_q;       prev_d = prev_q;     steps_d = steps_q;
    prevv_d = prevv_q;   second_d = second_q;
    anc_d = anc_q;       alink_d = alink_q;   new_d = new_q;
    head_d = head_q;     count_d = count_q;   used_d = used_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d = out_q;
    rd_en = 1'b0;  rd_addr = ptr_q[AW-1:0];
    dw_en = 1'b0;  dw_addr = ptr_q[AW-1:0];  dw_data = {tkey_q, ival_q};
    lw_en = 1'b0;  lw_addr = ptr_q[AW-1:0];  lw_data = NIL;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d    = in_item_i.cmd;
          ikey_d   = in_item_i.item_key;
          ival_d   = in_item_i.item_value;
          tkey_d   = in_item_i.target_key;
          ptr_d    = head_q;
          steps_d  = '0;
          prevv_d  = 1'b0;
          second_d = 1'b0;
          case (in_item_i.cmd)
            CMD_APPEND, CMD_PREPEND, CMD_INSERT, CMD_UPDATE: begin
              phase_d = PH_FIND;
              state_d = S_RD;
            end
            CMD_DELETE, CMD_LIST: begin
              phase_d = (in_item_i.cmd == CMD_DELETE) ? PH_DEL : PH_LIST;
              if (!node_ok(head_q, used_q)) begin
                status_d = ST_EMPTY;
                state_d  = S_STAT;
              end else begin
                state_d = S_RD;
              end
            end
            default: state_d = S_IDLE; // unused codes: no item out
          endcase
        end
      end
      S_RD: begin
        if (!node_ok(ptr_q, used_q) || steps_q > NIL) begin
          case (phase_q)
            PH_FIND: begin
              if (cmd_q == CMD_UPDATE) begin
                status_d = ST_KEYMISS;
                state_d  = S_STAT;
              end else if (cmd_q == CMD_INSERT && !second_q) begin
                status_d = ST_ANCMISS;
                state_d  = S_STAT;
              end else begin
                state_d = S_ALLOC;
              end
            end
            PH_TAIL: begin
              // list was empty before this append
              head_d   = new_q;
              status_d = ST_OK;
              state_d  = S_STAT;
            end
            PH_DEL: begin
              status_d = ST_KEYMISS;
              state_d  = S_STAT;
            end
            default: state_d = S_IDLE;
          endcase
        end else begin
          rd_en   = 1'b1;
          state_d = S_EV;
        end
      end
      S_EV: begin
        case (phase_q)
          PH_FIND: begin
            if (match) begin
              if (cmd_q == CMD_UPDATE) begin
                dw_en    = 1'b1;
                dw_data  = {tkey_q, ival_q};
                status_d = ST_OK;
                state_d  = S_STAT;
              end else if (cmd_q == CMD_INSERT && !second_q) begin
                // anchor found; now check the new key
                anc_d    = ptr_q;
                alink_d  = rd_link_q;
                second_d = 1'b1;
                ptr_d    = head_q;
                steps_d  = '0;
                state_d  = S_RD;
              end else begin
                status_d = ST_EXISTS;
                state_d  = S_STAT;
              end
            end else begin
              ptr_d   = rd_link_q;
              steps_d = steps_q + 1'b1;
              state_d = S_RD;
            end
          end
          PH_TAIL: begin
            if (node_ok(rd_link_q, used_q) && steps_q < NIL) begin
              ptr_d   = rd_link_q;
              steps_d = steps_q + 1'b1;
              state_d = S_RD;
            end else begin
              if (ptr_q == new_q) begin
                head_d = new_q;
              end else begin
                lw_en   = 1'b1;
                lw_data = new_q;
              end
              status_d = ST_OK;
              state_d  = S_STAT;
            end
          end
          PH_DEL: begin
            if (rd_key_q == tkey_q) begin
              if (prevv_q) begin
                lw_en   = 1'b1;
                lw_addr = prev_q[AW-1:0];
                lw_data = rd_link_q;
              end else begin
                head_d = rd_link_q;
              end
              used_d[ptr_q[AW-1:0]] = 1'b0;
              if (count_q != '0) count_d = count_q - 1'b1;
              status_d = ST_OK;
              state_d  = S_STAT;
            end else begin
              prev_d  = ptr_q;
              prevv_d = 1'b1;
              ptr_d   = rd_link_q;
              steps_d = steps_q + 1'b1;
              state_d = S_RD;
            end
          end
          default: begin // list
            if (out_space) begin
              out_valid_d       = 1'b1;
              out_d.status      = ST_OK;
              out_d.out_key     = rd_key_q;
              out_d.out_value   = rd_val_q;
              out_d.last        = !node_ok(rd_link_q, used_q) || (steps_q + 1'b1 >= NIL);
              if (out_d.last) begin
                state_d = S_IDLE;
              end else begin
                ptr_d   = rd_link_q;
                steps_d = steps_q + 1'b1;
                state_d = S_RD;
              end
            end
          end
        endcase
      end
      S_ALLOC: begin
        if (full) begin
          status_d = ST_FULL;
          state_d  = S_STAT;
        end else begin
          used_d[free_idx] = 1'b1;
          count_d = count_q + 1'b1;
          new_d   = {1'b0, free_idx};
          dw_en   = 1'b1;
          dw_addr = free_idx;
          dw_data = {ikey_q, ival_q};
          lw_en   = 1'b1;
          lw_addr = free_idx;
          case (cmd_q)
            CMD_PREPEND: begin
              lw_data  = head_q;
              head_d   = {1'b0, free_idx};
              status_d = ST_OK;
              state_d  = S_STAT;
            end
            CMD_INSERT: begin
              lw_data = alink_q;
              state_d = S_LINK;
            end
            default: begin // append: walk to tail
              lw_data = NIL;
              phase_d = PH_TAIL;
              ptr_d   = head_q;
              steps_d = '0;
              state_d = S_RD;
            end
          endcase
        end
      end
      S_LINK: begin
        lw_en    = 1'b1;
        lw_addr  = anc_q[AW-1:0];
        lw_data  = new_q;
        status_d = ST_OK;
        state_d  = S_STAT;
      end
      S_STAT: begin
        if (out_space) begin
          out_valid_d     = 1'b1;
          out_d.status    = status_q;
          out_d.out_key   = '0;
          out_d.out_value = '0;
          out_d.last      = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= NIL;
      count_q     <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q  <= phase_d;   cmd_q   <= cmd_d;   status_q <= status_d;
    ikey_q   <= ikey_d;    ival_q  <= ival_d;  tkey_q   <= tkey_d;
    ptr_q    <= ptr_d;     prev_q  <= prev_d;  steps_q  <= steps_d;
    prevv_q  <= prevv_d;   second_q <= second_d;
    anc_q    <= anc_d;     alink_q <= alink_d; new_q    <= new_d;
    out_q    <= out_d;
  end

  // node memories, read data registered
  always_ff @(posedge clk_i) begin
    if (dw_en) data_mem[dw_addr] <= dw_data;
    if (lw_en) link_mem[lw_addr] <= lw_data;
    if (rd_en) begin
      {rd_key_q, rd_val_q} <= data_mem[rd_addr];
      rd_link_q            <= link_mem[rd_addr];
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // count tracks the valid bits
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_q) == int'(count_q))
    else $error("node count out of step with valid bits");

  // memory read never overlaps a write in the same cycle
  a_no_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> !(dw_en || lw_en))
    else $error("read issued during write");

  // head is either null or a live node when idle
  a_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (head_q == NIL || node_ok(head_q, used_q)))
    else $error("head points at a free node");

  // evaluate follows a read issue, or holds while a list item waits
  a_ev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EV) |-> $past(rd_en || state_q == S_EV))
    else $error("node data used without a read");

endmodule

// File: dv/keyed_ordered_list_manager_tb.sv
`timescale 1ns / 1ps
module keyed_ordered_list_manager_tb;
  import kolm_pkg::*;

  // Golden list state and the queue of results it predicts.
  class list_scoreboard;
    logic [31:0] node_key [CAP];
    logic [31:0] node_val [CAP];
    int          node_nxt [CAP];
    bit          node_used[CAP];
    int          head;
    int          count;
    out_item_t   pending[$];
    int          errors;

    function new();
      head = CAP;
      count = 0;
      errors = 0;
      foreach (node_used[i]) node_used[i] = 0;
    endfunction

    function bit live(int i);
      return i >= 0 && i < CAP && node_used[i];
    endfunction

    // Walk with a step bound; returns the node holding k or CAP.
    function int lookup(logic [31:0] k);
      int p;
      int n;
      p = head;
      n = 0;
      while (live(p) && n < CAP) begin
        if (node_key[p] == k) return p;
        p = node_nxt[p];
        n++;
      end
      return CAP;
    endfunction

    function int tail_node();
      int p;
      int n;
      p = head;
      n = 0;
      if (!live(p)) return CAP;
      while (n < CAP && live(node_nxt[p])) begin
        p = node_nxt[p];
        n++;
      end
      return p;
    endfunction

    function int grab(logic [31:0] k, logic [31:0] v);
      if (count >= CAP) return CAP;
      for (int i = 0; i < CAP; i++) begin
        if (!node_used[i]) begin
          node_used[i] = 1;
          node_key[i] = k;
          node_val[i] = v;
          node_nxt[i] = CAP;
          count++;
          return i;
        end
      end
      return CAP;
    endfunction

    function void push(logic [2:0] st, logic [31:0] k, logic [31:0] v, logic l);
      out_item_t r;
      r.status = st;
      r.out_key = k;
      r.out_value = v;
      r.last = l;
      pending.push_back(r);
    endfunction

    // Note an accepted command and queue what it must produce.
    function void note_command(in_item_t c);
      logic [2:0] st;
      int p;
      int q;
      int n;
      int steps;
      st = ST_OK;
      case (c.cmd)
        CMD_APPEND: begin
          if (lookup(c.item_key) != CAP) st = ST_EXISTS;
          else begin
            n = grab(c.item_key, c.item_value);
            if (n == CAP) st = ST_FULL;
            else begin
              p = tail_node();
              // tail walk sees the new node only when the list was empty
              if (p == CAP || p == n) head = n;
              else node_nxt[p] = n;
            end
          end
        end
        CMD_PREPEND: begin
          if (lookup(c.item_key) != CAP) st = ST_EXISTS;
          else begin
            p = head;
            n = grab(c.item_key, c.item_value);
            if (n == CAP) st = ST_FULL;
            else begin
              node_nxt[n] = p;
              head = n;
            end
          end
        end
        CMD_INSERT: begin
          p = lookup(c.target_key);
          if (p == CAP) st = ST_ANCMISS;
          else if (lookup(c.item_key) != CAP) st = ST_EXISTS;
          else begin
            n = grab(c.item_key, c.item_value);
            if (n == CAP) st = ST_FULL;
            else begin
              node_nxt[n] = node_nxt[p];
              node_nxt[p] = n;
            end
          end
        end
        CMD_DELETE: begin
          if (!live(head)) st = ST_EMPTY;
          else if (node_key[head] == c.target_key) begin
            node_used[head] = 0;
            head = node_nxt[head];
            if (count > 0) count--;
          end else begin
            st = ST_KEYMISS;
            p = head;
            steps = 0;
            while (steps < CAP && live(node_nxt[p])) begin
              q = node_nxt[p];
              if (node_key[q] == c.target_key) begin
                node_nxt[p] = node_nxt[q];
                node_used[q] = 0;
                if (count > 0) count--;
                st = ST_OK;
                break;
              end
              p = q;
              steps++;
            end
          end
        end
        CMD_UPDATE: begin
          p = lookup(c.target_key);
          if (p == CAP) st = ST_KEYMISS;
          else node_val[p] = c.item_value;
        end
        CMD_LIST: begin
          if (!live(head)) begin
            push(ST_EMPTY, '0, '0, 1'b1);
          end else begin
            p = head;
            n = 0;
            while (live(p) && n < CAP) begin
              q = node_nxt[p];
              push(ST_OK, node_key[p], node_val[p],
                   !(live(q) && n + 1 < CAP));
              n++;
              p = q;
            end
          end
          return;
        end
        default: return; // unused codes produce nothing
      endcase
      push(st, '0, '0, 1'b1);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (pending.size() == 0) begin
        $display("%0t unexpected result: got %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status) begin
        $display("%0t status: expected %0d actual %0d", $time, exp.status, got.status);
        errors++;
      end
      if (got.out_key !== exp.out_key) begin
        $display("%0t out_key: expected %h actual %h", $time, exp.out_key, got.out_key);
        errors++;
      end
      if (got.out_value !== exp.out_value) begin
        $display("%0t out_value: expected %h actual %h", $time, exp.out_value,
                 got.out_value);
        errors++;
      end
      if (got.last !== exp.last) begin
        $display("%0t last: expected %0b actual %0b", $time, exp.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  list_scoreboard sb;
  int  cycles;
  bit  rx_hold;        // long receiver hold-off request
  logic [31:0] keys_used[$];   // small key pool so hits are common

  keyed_ordered_list_manager dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Drive one command, with a random lead gap, and wait for its acceptance.
  // Valid stays up after acceptance until the next command or a drain.
  task automatic send_cmd(logic [2:0] c, logic [31:0] ik, logic [31:0] iv,
                          logic [31:0] tk, bit no_gap = 0);
    in_item_t it;
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19));
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    it.cmd = c;
    it.item_key = ik;
    it.item_value = iv;
    it.target_key = tk;
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_command(it);
  endtask

  function automatic logic [31:0] pick_key();
    if (keys_used.size() > 0 && $urandom_range(0, 2) != 0)
      return keys_used[$urandom_range(0, keys_used.size() - 1)];
    return (($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 47));
  endfunction

  // Random command mix; inserts tend to grow the list so it reaches full.
  task automatic random_cmd(bit grow);
    logic [2:0] c;
    logic [31:0] ik;
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) c = 3'($urandom_range(6, 7));
    else if (grow) c = (r < 30) ? CMD_APPEND : (r < 55) ? CMD_PREPEND :
                       (r < 80) ? CMD_INSERT : (r < 88) ? CMD_UPDATE :
                       (r < 94) ? CMD_DELETE : CMD_LIST;
    else c = (r < 15) ? CMD_APPEND : (r < 25) ? CMD_PREPEND :
             (r < 40) ? CMD_INSERT : (r < 70) ? CMD_DELETE :
             (r < 85) ? CMD_UPDATE : CMD_LIST;
    ik = ($urandom_range(0, 1) == 0) ? pick_key() : $urandom();
    if (c inside {CMD_APPEND, CMD_PREPEND, CMD_INSERT}) keys_used.push_back(ik);
    send_cmd(c, ik, $urandom(), pick_key());
  endtask

  // Drop valid and let the expected results drain.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4 * CAP + 10) @(posedge clk_i);
  endtask

  // Receiver: random stalls per item, or a long hold when asked.
  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (rx_hold) begin
        out_ready_i <= 1'b0;
        repeat (600) @(posedge clk_i);
        rx_hold = 0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(out_item_o);
    end
  end

  // Timeout watchdog.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 2000000) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Directed then random stimulus.
  initial begin
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    rx_hold = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty-list corner cases.
    send_cmd(CMD_LIST, 0, 0, 0);
    send_cmd(CMD_DELETE, 0, 0, 5);
    send_cmd(CMD_UPDATE, 0, 1, 5);
    send_cmd(CMD_INSERT, 7, 1, 5);         // anchor missing
    // Extreme keys and values.
    send_cmd(CMD_APPEND, 32'h7fffffff, 32'h80000000, 0);
    send_cmd(CMD_PREPEND, 32'h80000000, 32'h7fffffff, 0);
    send_cmd(CMD_APPEND, 32'hffffffff, 32'hffffffff, 0);
    send_cmd(CMD_APPEND, 0, 0, 0);
    send_cmd(CMD_APPEND, 0, 9, 0);          // duplicate append
    send_cmd(CMD_PREPEND, 32'hffffffff, 3, 0); // duplicate prepend
    send_cmd(CMD_INSERT, 0, 3, 32'h80000000);  // anchor ok, key exists
    send_cmd(CMD_INSERT, 5, 3, 32'h80000000);
    send_cmd(CMD_INSERT, 6, 3, 0);          // after tail
    send_cmd(CMD_UPDATE, 0, 32'h55555555, 6);
    send_cmd(CMD_DELETE, 0, 0, 32'h80000000);  // head
    send_cmd(CMD_DELETE, 0, 0, 6);          // tail
    send_cmd(CMD_DELETE, 0, 0, 1234);       // missing
    send_cmd(3'd6, 1, 1, 1);
    send_cmd(3'd7, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_cmd(CMD_LIST, 0, 0, 0);
    drain();

    // Fill the pool to hit the full status, then list all of it.
    for (int i = 0; i < CAP + 2; i++)
      send_cmd(i[0] ? CMD_PREPEND : CMD_APPEND, 100 + i, $urandom(), 0);
    send_cmd(CMD_INSERT, 999, 1, 100);      // full on insert
    send_cmd(CMD_LIST, 0, 0, 0);
    drain();

    // Long receiver hold while lists keep coming, to back up the block.
    rx_hold = 1;
    for (int i = 0; i < 6; i++) send_cmd(CMD_LIST, 0, 0, 0, 1);
    for (int i = 0; i < CAP; i++) send_cmd(CMD_DELETE, 0, 0, 100 + i);

    // Random part: alternate growing and shrinking phases.
    for (int i = 0; i < 300; i++) begin
      random_cmd((i / 50) % 2 == 0);
      if (keys_used.size() > 64) void'(keys_used.pop_front());
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: keyed_ordered_list_manager.f
hdl/kolm_pkg.sv
hdl/keyed_ordered_list_manager.sv
dv/keyed_ordered_list_manager_tb.sv
